// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define HSL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsl assertion failed");

// clocked assertion that is also checked during reset
`define HSL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hsl assertion failed");

`endif

// ===== src/hsl_pkg.sv =====
// shared types and constants for the hsl to rgba converter
// no dependencies
package hsl_pkg;

    localparam int PCT_W      = 7;
    localparam int HUE_W      = 9;
    localparam int LEVEL_W    = 14;   // levels in units of 1/10000
    localparam int NUM_W      = 20;   // ramp value times 600000
    localparam int SCALED_W   = 24;   // ramp numerator times 17
    localparam int CHAN_W     = 8;
    localparam int STAGES     = 4;

    localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
    localparam logic [PCT_W-1:0] LIGHT_HALF = 7'd50;
    localparam logic [PCT_W-1:0] SAT_RESET  = 7'd100;
    localparam logic [PCT_W-1:0] LIGHT_RESET = 7'd50;

    localparam logic [HUE_W:0] HUE_TURN  = 10'd360;
    localparam logic [HUE_W:0] HUE_THIRD = 10'd120;
    localparam logic [HUE_W:0] HUE_2THIRD = 10'd240;

    localparam logic [HUE_W-1:0] RAMP_UP_END   = 9'd60;
    localparam logic [HUE_W-1:0] RAMP_HI_END   = 9'd180;
    localparam logic [HUE_W-1:0] RAMP_DOWN_END = 9'd240;

    // floor(num * 255 / 600000) == floor(num * 17 / 40000)
    localparam int  DIV_CONST  = 40000;
    localparam int  DIV_SHIFT  = 32;
    localparam int  PROD_W     = 41;
    localparam logic [16:0] DIV_RECIP = 17'd107374;   // floor(2^32 / 40000)

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // register indexes
    localparam logic REG_SATURATION = 1'b0;
    localparam logic REG_LIGHTNESS  = 1'b1;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [HUE_W-1:0]   pos_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    typedef struct packed {
        logic              advance;
        logic [STAGES-1:0] valid;
    } pipe_ctrl_t;

endpackage

// ===== src/hsl_flow.sv =====
// valid bits and stall control for the converter pipeline
// depends on hsl_pkg
module hsl_flow
    import hsl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output pipe_ctrl_t ctrl
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic              advance;

    // whole pipe moves unless the output beat is held
    assign advance = !valid_reg[STAGES-1] || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = {valid_reg[STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready      = advance;
    assign m_valid      = valid_reg[STAGES-1];
    assign ctrl.advance = advance;
    assign ctrl.valid   = valid_reg;

endmodule

// ===== src/hsl_front.sv =====
// first stage: clamps settings, forms upper and lower levels, hue positions
// depends on hsl_pkg
module hsl_front
    import hsl_pkg::*;
(
    input  logic             aclk,
    input  pipe_ctrl_t       ctrl,
    input  logic [PCT_W-1:0] sat_pct,
    input  logic [PCT_W-1:0] light_pct,
    input  logic [HUE_W-1:0] hue,
    output level_t           lo,
    output level_t           hi,
    output pos_t             pos_r,
    output pos_t             pos_g,
    output pos_t             pos_b
);

    logic [PCT_W-1:0] s;
    logic [PCT_W-1:0] l;
    logic [13:0]      sl;
    logic [14:0]      l100;
    logic [14:0]      s100;
    logic [14:0]      l200;
    level_t           hi_next;
    level_t           lo_next;
    logic [HUE_W:0]   h;
    logic [HUE_W:0]   sum_r;
    logic [HUE_W:0]   sum_b;
    pos_t             pos_r_next;
    pos_t             pos_g_next;
    pos_t             pos_b_next;
    level_t           lo_reg;
    level_t           hi_reg;
    pos_t             pos_r_reg;
    pos_t             pos_g_reg;
    pos_t             pos_b_reg;

    always_comb begin
        s    = (sat_pct > PCT_MAX) ? PCT_MAX : sat_pct;
        l    = (light_pct > PCT_MAX) ? PCT_MAX : light_pct;
        sl   = 14'(s) * 14'(l);
        l100 = 15'(l) * 15'd100;
        s100 = 15'(s) * 15'd100;
        l200 = 15'(l) * 15'd200;
        if (l < LIGHT_HALF) begin
            hi_next = LEVEL_W'(l100 + 15'(sl));
        end else begin
            hi_next = LEVEL_W'(l100 + s100 - 15'(sl));
        end
        lo_next = LEVEL_W'(l200 - 15'(hi_next));

        h = {1'b0, hue};
        if (h >= HUE_TURN) begin
            h = h - HUE_TURN;
        end
        sum_r = h + HUE_THIRD;
        if (sum_r >= HUE_TURN) begin
            sum_r = sum_r - HUE_TURN;
        end
        // minus one third wraps to plus two thirds
        sum_b = h + HUE_2THIRD;
        if (sum_b >= HUE_TURN) begin
            sum_b = sum_b - HUE_TURN;
        end
        pos_r_next = sum_r[HUE_W-1:0];
        pos_g_next = h[HUE_W-1:0];
        pos_b_next = sum_b[HUE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            pos_r_reg <= pos_r_next;
            pos_g_reg <= pos_g_next;
            pos_b_reg <= pos_b_next;
        end
    end

    assign lo    = lo_reg;
    assign hi    = hi_reg;
    assign pos_r = pos_r_reg;
    assign pos_g = pos_g_reg;
    assign pos_b = pos_b_reg;

endmodule

// ===== src/hsl_chan.sv =====
// one color channel: ramp sample, scale by 255/600000 via reciprocal, correct
// depends on hsl_pkg; stages two to four of the pipeline
module hsl_chan
    import hsl_pkg::*;
(
    input  logic       aclk,
    input  pipe_ctrl_t ctrl,
    input  level_t     lo,
    input  level_t     hi,
    input  pos_t       pos,
    output chan_t      value
);

    level_t              d;
    level_t              base;
    logic [5:0]          frac;
    logic [NUM_W-1:0]    num_next;
    logic [NUM_W-1:0]    num_reg;
    logic [SCALED_W-1:0] x_next;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] x_reg;
    logic [HUE_W-1:0]    q_est_reg;
    logic [SCALED_W:0]   rem;
    logic [HUE_W-1:0]    q;
    chan_t               value_next;
    chan_t               value_reg;

    // piecewise ramp: rise, flat high, fall, flat low
    always_comb begin
        d = hi - lo;
        if (pos < RAMP_UP_END) begin
            base = lo;
            frac = pos[5:0];
        end else if (pos < RAMP_HI_END) begin
            base = hi;
            frac = '0;
        end else if (pos < RAMP_DOWN_END) begin
            base = lo;
            frac = 6'(RAMP_DOWN_END - pos);
        end else begin
            base = lo;
            frac = '0;
        end
        num_next = NUM_W'(base) * NUM_W'(60) + NUM_W'(d) * NUM_W'(frac);
    end

    always_comb begin
        x_next = SCALED_W'({num_reg, 4'b0000}) + SCALED_W'(num_reg);
        prod   = PROD_W'(x_next) * PROD_W'(DIV_RECIP);
    end

    // reciprocal estimate is low by at most one
    always_comb begin
        rem = (SCALED_W+1)'(x_reg) - (SCALED_W+1)'(q_est_reg) * (SCALED_W+1)'(DIV_CONST);
        q   = q_est_reg;
        if (rem >= (SCALED_W+1)'(DIV_CONST)) begin
            q = q_est_reg + 1'b1;
        end
        value_next = (q > HUE_W'(255)) ? chan_t'(255) : q[CHAN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            num_reg   <= num_next;
            x_reg     <= x_next;
            q_est_reg <= prod[PROD_W-1:DIV_SHIFT];
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== src/hsl_to_rgba_converter.sv =====
// hsl to rgba converter: hue in, packed rgba out, s and l from registers
// each input beat passes four registered stages; one beat per cycle unless the output beat is held
// the four stages stall together only while the output beat is held
// reset (aresetn low, synchronous) clears the valid bits and sets
// saturation to 100 and lightness to 50 percent
// depends on hsl_pkg, hsl_flow, hsl_front, hsl_chan
module hsl_to_rgba_converter
    import hsl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [PCT_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [HUE_W-1:0] s_hue_degrees,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_rgba
);

    logic [PCT_W-1:0] sat_reg;
    logic [PCT_W-1:0] light_reg;
    pipe_ctrl_t       ctrl;
    level_t           lo;
    level_t           hi;
    pos_t             pos_r;
    pos_t             pos_g;
    pos_t             pos_b;
    chan_t            red;
    chan_t            green;
    chan_t            blue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg   <= SAT_RESET;
            light_reg <= LIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SATURATION: sat_reg   <= cfg_wdata;
                REG_LIGHTNESS:  light_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    hsl_flow u_flow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    hsl_front u_front (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .sat_pct   (sat_reg),
        .light_pct (light_reg),
        .hue       (s_hue_degrees),
        .lo        (lo),
        .hi        (hi),
        .pos_r     (pos_r),
        .pos_g     (pos_g),
        .pos_b     (pos_b)
    );

    hsl_chan u_chan_r (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .lo    (lo),
        .hi    (hi),
        .pos   (pos_r),
        .value (red)
    );

    hsl_chan u_chan_g (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .lo    (lo),
        .hi    (hi),
        .pos   (pos_g),
        .value (green)
    );

    hsl_chan u_chan_b (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .lo    (lo),
        .hi    (hi),
        .pos   (pos_b),
        .value (blue)
    );

    assign m_rgba = {red, green, blue, ALPHA_OPAQUE};

endmodule

// ===== src/hsl_checker.sv =====
// port-level checks for hsl_to_rgba_converter, bound to the top level
// depends on assert_macros.svh and hsl_pkg
`include "assert_macros.svh"

module hsl_checker
    import hsl_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [31:0]      m_rgba
);

    // alpha byte is constant on every output beat
    `HSL_ASSERT(a_alpha_opaque, aclk, aresetn, m_valid |-> m_rgba[7:0] == ALPHA_OPAQUE)

    // a held output beat keeps its value
    `HSL_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_rgba))

    // input side only stalls behind a held output beat
    `HSL_ASSERT(a_ready_link, aclk, aresetn, s_ready == (!m_valid || m_ready))

    // an entered beat reaches the output when the sink keeps taking until then
    `HSL_ASSERT(a_latency, aclk, aresetn, (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)

    // output is empty right after reset
    `HSL_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind hsl_to_rgba_converter hsl_checker u_hsl_checker (.*);

// ===== sim/hsl_to_rgba_converter_tb.sv =====
// testbench for hsl_to_rgba_converter: directed table, then random hues over
// random saturation/lightness settings, each beat checked against a typed word or a predictor
// depends on hsl_pkg and the converter rtl
module hsl_to_rgba_converter_tb
    import hsl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit KNOWN = 1'b1;   // expected word typed into the table
    localparam bit CALC  = 1'b0;   // expected word comes from the predictor

    localparam int N_DIRECTED   = 22;
    localparam int N_SEGMENTS   = 14;
    localparam int SEG_BEATS    = 50;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] light;
        logic [HUE_W-1:0] hue;
        bit               known;
        logic [31:0]      rgba;
    } color_row_t;

    localparam color_row_t DIRECTED [0:N_DIRECTED-1] = '{
        '{7'd100, 7'd50,  9'd0,   KNOWN, 32'hFF0000FF},
        '{7'd100, 7'd50,  9'd120, KNOWN, 32'h00FF00FF},
        '{7'd100, 7'd50,  9'd240, KNOWN, 32'h0000FFFF},
        '{7'd100, 7'd50,  9'd60,  KNOWN, 32'hFFFF00FF},
        '{7'd100, 7'd50,  9'd180, KNOWN, 32'h00FFFFFF},
        '{7'd100, 7'd50,  9'd359, CALC,  32'h0},
        '{7'd100, 7'd50,  9'd360, KNOWN, 32'hFF0000FF},
        '{7'd100, 7'd50,  9'd511, CALC,  32'h0},
        '{7'd100, 7'd50,  9'd300, CALC,  32'h0},
        '{7'd0,   7'd50,  9'd0,   KNOWN, 32'h7F7F7FFF},
        '{7'd0,   7'd50,  9'd200, KNOWN, 32'h7F7F7FFF},
        '{7'd0,   7'd0,   9'd90,  KNOWN, 32'h000000FF},
        '{7'd100, 7'd100, 9'd45,  KNOWN, 32'hFFFFFFFF},
        '{7'd127, 7'd127, 9'd200, KNOWN, 32'hFFFFFFFF},
        '{7'd127, 7'd25,  9'd30,  CALC,  32'h0},
        '{7'd127, 7'd25,  9'd180, CALC,  32'h0},
        '{7'd0,   7'd127, 9'd0,   KNOWN, 32'hFFFFFFFF},
        '{7'd50,  7'd49,  9'd10,  CALC,  32'h0},
        '{7'd50,  7'd50,  9'd10,  CALC,  32'h0},
        '{7'd1,   7'd1,   9'd255, CALC,  32'h0},
        '{7'd100, 7'd0,   9'd0,   KNOWN, 32'h000000FF},
        '{7'd37,  7'd83,  9'd419, CALC,  32'h0}
    };

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             cfg_wr_en     = 1'b0;
    logic             cfg_index     = REG_SATURATION;
    logic [PCT_W-1:0] cfg_wdata     = '0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [HUE_W-1:0] s_hue_degrees = '0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [31:0]      m_rgba;

    logic [PCT_W-1:0] sat_now   = SAT_RESET;
    logic [PCT_W-1:0] light_now = LIGHT_RESET;
    logic [31:0]      rgba_pending_q [$];
    logic [31:0]      rgba_want;
    int               src_idle_pct  = 6;
    int               sink_idle_pct = 62;
    int               errors        = 0;

    hsl_to_rgba_converter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_hue_degrees (s_hue_degrees),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rgba        (m_rgba)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // one channel: ramp between lower and upper level (1/10000 units) at
    // position pos (1/360 turn), scaled to 0..255 and truncated
    function automatic logic [CHAN_W-1:0] ramp_level(input longint unsigned lower,
                                                      input longint unsigned upper,
                                                      input int unsigned pos);
        longint unsigned span;
        longint unsigned num;
        longint unsigned scaled;
        span = upper - lower;
        if (pos < 60)
            num = lower * 60 + span * pos;
        else if (pos < 180)
            num = upper * 60;
        else if (pos < 240)
            num = lower * 60 + span * (240 - pos);
        else
            num = lower * 60;
        scaled = (num * 255) / 600000;
        if (scaled > 255)
            scaled = 255;
        return scaled[CHAN_W-1:0];
    endfunction

    function automatic logic [31:0] predict_rgba(input logic [PCT_W-1:0] sat_pct,
                                                 input logic [PCT_W-1:0] light_pct,
                                                 input logic [HUE_W-1:0] hue);
        int unsigned s;
        int unsigned l;
        int unsigned h;
        int unsigned upper;
        int unsigned lower;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        s = (sat_pct > 100) ? 100 : sat_pct;
        l = (light_pct > 100) ? 100 : light_pct;
        h = hue;
        if (h >= 360)
            h = h - 360;
        if (l < 50)
            upper = l * (100 + s);
        else
            upper = (l + s) * 100 - s * l;
        lower = 200 * l - upper;
        red   = ramp_level(lower, upper, (h + 120) % 360);
        green = ramp_level(lower, upper, h);
        blue  = ramp_level(lower, upper, (h + 240) % 360);
        return {red, green, blue, 8'hFF};
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_hue(input logic [HUE_W-1:0] hue, input logic [31:0] rgba_exp);
        bit taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_hue_degrees <= hue;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            if (taken)
                rgba_pending_q.push_back(rgba_exp);
            @(posedge aclk);
        end
    endtask

    task automatic finish_outstanding();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rgba_pending_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [PCT_W-1:0] sat_pct,
                                  input logic [PCT_W-1:0] light_pct);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SATURATION;
        cfg_wdata <= sat_pct;
        @(posedge aclk);
        cfg_index <= REG_LIGHTNESS;
        cfg_wdata <= light_pct;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sat_now   = sat_pct;
        light_now = light_pct;
    endtask

    function automatic logic [PCT_W-1:0] pick_pct();
        case ($urandom_range(5))
            0:       return 7'd0;
            1:       return PCT_MAX;
            2:       return 7'($urandom_range(127, 101));
            default: return 7'($urandom_range(100));
        endcase
    endfunction

    always @(posedge aclk)
        m_ready <= aresetn && ($urandom_range(99) >= sink_idle_pct);

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rgba_pending_q.size() == 0) begin
                $display("%0t: rgba beat %08h with none expected", $time, m_rgba);
                errors++;
            end else begin
                rgba_want = rgba_pending_q.pop_front();
                if (m_rgba !== rgba_want) begin
                    $display("%0t: rgba mismatch, expected %08h, got %08h",
                             $time, rgba_want, m_rgba);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [HUE_W-1:0] hue;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].sat != sat_now || DIRECTED[i].light != light_now) begin
                finish_outstanding();
                write_settings(DIRECTED[i].sat, DIRECTED[i].light);
            end
            send_hue(DIRECTED[i].hue,
                     DIRECTED[i].known ? DIRECTED[i].rgba
                                       : predict_rgba(sat_now, light_now, DIRECTED[i].hue));
        end

        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            finish_outstanding();
            // sink mostly stalls, then source mostly idles, then full rate
            if (seg < 5) begin
                src_idle_pct  = 6;
                sink_idle_pct = 62;
            end else if (seg < 10) begin
                src_idle_pct  = 62;
                sink_idle_pct = 6;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_settings(pick_pct(), pick_pct());
            for (int n = 0; n < SEG_BEATS; n++) begin
                if ($urandom_range(9) == 0)
                    hue = 9'($urandom_range(511, 360));
                else
                    hue = 9'($urandom_range(359));
                send_hue(hue, predict_rgba(sat_now, light_now, hue));
            end
        end

        finish_outstanding();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && rgba_pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
